>>> rtl/core/digital_pan_tilt_zoom_crop_top_macros.svh
// ----------------------------------------------------------------------------
// Digital pan-tilt-zoom crop: assertion macros
// Shared assertion forms, clocked on i_clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef DIGITAL_PAN_TILT_ZOOM_CROP_TOP_MACROS_SVH
`define DIGITAL_PAN_TILT_ZOOM_CROP_TOP_MACROS_SVH

// Same-cycle implication.
`define DPTZ_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define DPTZ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/dptz_pkg.sv
// ----------------------------------------------------------------------------
// Digital pan-tilt-zoom crop: package
// Field widths, command codes, register indexes and shared types.
// ----------------------------------------------------------------------------
package dptz_pkg;

    localparam int DIM_WIDTH = 14;  // source and crop dimension width
    localparam int SRC_W  = DIM_WIDTH;      // source size and crop size
    localparam int OFS_W  = DIM_WIDTH - 1;  // crop offset
    localparam int ZOOM_W = 16;  // zoom state, Q4.12
    localparam int CTR_W  = 17;  // center state, Q1.16
    localparam int ARG_W  = 18;  // command arguments
    localparam int SUM_W  = ARG_W + 1;
    localparam int PROD_W = 30;  // center * source
    localparam int CNT_W  = 4;
    localparam logic [CNT_W-1:0] ITER_LAST = CNT_W'(SRC_W - 1);

    localparam logic [ZOOM_W-1:0] ZOOM_ONE    = 16'd4096;
    localparam logic [ZOOM_W-1:0] ZOOM_MAX    = 16'd32768;
    localparam logic [CTR_W-1:0]  CENTER_ONE  = 17'd65536;
    localparam logic [CTR_W-1:0]  CENTER_HALF = 17'd32768;

    localparam logic [SRC_W-1:0] SRC_W_RESET = 14'd2592;
    localparam logic [SRC_W-1:0] SRC_H_RESET = 14'd1944;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT = 2'd1;

    typedef enum logic [2:0] {
        OP_SET_ZOOM   = 3'd0,
        OP_ZOOM_STEP  = 3'd1,
        OP_SET_CENTER = 3'd2,
        OP_PAN        = 3'd3,
        OP_TILT       = 3'd4,
        OP_RESET_VIEW = 3'd5,
        OP_ENABLE     = 3'd6,
        OP_REAPPLY    = 3'd7
    } t_opcode;

    typedef struct packed {
        logic [OFS_W-1:0] offset;
        logic [SRC_W-1:0] size;
    } t_axis_res;

endpackage

>>> rtl/core/dptz_axis.sv
// ----------------------------------------------------------------------------
// Digital pan-tilt-zoom crop: axis unit
// Bit-serial divide of source size by zoom and bit-serial center scaling,
// then clamping of crop size and offset for one axis.
// ----------------------------------------------------------------------------
module dptz_axis #(
    parameter int MIN_CROP  = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [dptz_pkg::SRC_W-1:0]      i_src,
    input  logic [dptz_pkg::ZOOM_W-1:0]     i_zoom,
    input  logic [dptz_pkg::CTR_W-1:0]      i_center,
    output logic                            o_done,
    output dptz_pkg::t_axis_res             o_res
);

    localparam int SW = dptz_pkg::SRC_W;
    localparam int PW = dptz_pkg::PROD_W;
    localparam logic [SW+2:0]  SRC_LIMIT = (SW+3)'(1) << (dptz_pkg::DIM_WIDTH - 1);
    localparam logic [SW-1:0]  MIN_SIZE  = SW'(MIN_CROP);

    typedef enum logic [1:0] {A_IDLE, A_ITER, A_SIZE, A_OFFS} t_astate;

    t_astate                      r_state;
    logic [dptz_pkg::CNT_W-1:0]   r_cnt;
    logic [SW-1:0]                r_src;
    logic [dptz_pkg::ZOOM_W-1:0]  r_zoom;
    logic [dptz_pkg::CTR_W-1:0]   r_center;
    logic [SW-1:0]                r_mbits;
    logic [SW-1:0]                r_dbits;
    logic [dptz_pkg::ZOOM_W-1:0]  r_rem;
    logic [SW-1:0]                r_quo;
    logic [PW-1:0]                r_prod;
    logic [SW-1:0]                r_size;
    logic                         r_done;
    dptz_pkg::t_axis_res          r_res;

    logic [SW-1:0]                src_lim;
    logic [dptz_pkg::ZOOM_W:0]    trial;
    logic                         ge;
    logic [dptz_pkg::ZOOM_W:0]    diff;
    logic [dptz_pkg::ZOOM_W-1:0]  n_rem;
    logic [PW-1:0]                n_prod;
    logic [SW-1:0]                size_min;
    logic [SW-1:0]                size_cap;
    logic [SW-1:0]                pos;
    logic [SW-1:0]                half;
    logic [SW-1:0]                room;
    logic [SW-1:0]                offs_raw;
    logic [SW-1:0]                offs_cap;

    always_comb begin
        src_lim  = ((SW+3)'(i_src) > SRC_LIMIT) ? SRC_LIMIT[SW-1:0] : i_src;
        // restoring divide step
        trial    = {r_rem, r_dbits[SW-1]};
        ge       = trial >= {1'b0, r_zoom};
        diff     = trial - {1'b0, r_zoom};
        n_rem    = ge ? diff[dptz_pkg::ZOOM_W-1:0] : trial[dptz_pkg::ZOOM_W-1:0];
        // shift-add multiply step, source bits MSB first
        n_prod   = {r_prod[PW-2:0], 1'b0} + (r_mbits[SW-1] ? PW'(r_center) : '0);
        size_min = (r_quo < MIN_SIZE) ? MIN_SIZE : r_quo;
        size_cap = (size_min > r_src) ? r_src : size_min;
        pos      = r_prod[PW-1:16];
        half     = {1'b0, r_size[SW-1:1]};
        room     = r_src - r_size;
        offs_raw = pos - half;
        if (pos < half) begin
            offs_cap = '0;
        end else if (offs_raw > room) begin
            offs_cap = room;
        end else begin
            offs_cap = offs_raw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= (r_state == A_OFFS);
            case (r_state)
                A_IDLE: begin
                    if (i_start) begin
                        r_src    <= src_lim;
                        r_zoom   <= i_zoom;
                        r_center <= i_center;
                        r_mbits  <= src_lim;
                        r_dbits  <= {src_lim[1:0], {(SW-2){1'b0}}};
                        r_rem    <= dptz_pkg::ZOOM_W'(src_lim[SW-1:2]);
                        r_quo    <= '0;
                        r_prod   <= '0;
                        r_cnt    <= '0;
                        r_state  <= A_ITER;
                    end
                end
                A_ITER: begin
                    r_rem   <= n_rem;
                    r_quo   <= {r_quo[SW-2:0], ge};
                    r_prod  <= n_prod;
                    r_mbits <= {r_mbits[SW-2:0], 1'b0};
                    r_dbits <= {r_dbits[SW-2:0], 1'b0};
                    r_cnt   <= r_cnt + 1'b1;
                    if (r_cnt == dptz_pkg::ITER_LAST) begin
                        r_state <= A_SIZE;
                    end
                end
                A_SIZE: begin
                    r_size  <= {size_cap[SW-1:1], 1'b0};
                    r_state <= A_OFFS;
                end
                A_OFFS: begin
                    r_res.offset <= {offs_cap[dptz_pkg::OFS_W-1:1], 1'b0};
                    r_res.size   <= r_size;
                    r_state      <= A_IDLE;
                end
                default: begin
                    r_state <= A_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

>>> rtl/core/digital_pan_tilt_zoom_crop_top.sv
// ----------------------------------------------------------------------------
// Digital pan-tilt-zoom crop: top level
// Command decoder, view state and crop rectangle output register.
// ----------------------------------------------------------------------------
// Each command item updates the view (zoom Q4.12 held in 1.0..8.0, center
// Q1.16 held in 0..1, crop on flag). A command that leaves the crop off and
// is not enable or reapply produces no result, and o_in_ready stays high. A
// command that produces a result starts both axis units, which run in
// parallel: each does a 14-step bit-serial divide of the source size by the
// zoom alongside a 14-step shift-add scaling of the center, then two clamp
// steps. After both units report done, the sequencer loads the result into
// the output register and can take the next item in the cycle after that
// load, so the block takes no new item while a computation is still running.
// The output register holds a result until it is taken while the next
// command already runs; a finished computation waits only if the previous
// result is still held. With the crop off the result reads crop_enable=0
// and all zero coordinates. Source size registers are written through the
// config channel, which is always ready; an index other than width or height is dropped.
// ----------------------------------------------------------------------------
module digital_pan_tilt_zoom_crop_top #(
    parameter int MIN_CROP  = 64
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // command channel
    input  logic                                    i_in_valid,
    output logic                                    o_in_ready,
    input  logic [2:0]                              i_opcode,
    input  logic signed [dptz_pkg::ARG_W-1:0]       i_zoom_arg,
    input  logic signed [dptz_pkg::ARG_W-1:0]       i_center_x_arg,
    input  logic signed [dptz_pkg::ARG_W-1:0]       i_center_y_arg,
    input  logic                                    i_enable_arg,
    // configuration channel
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [dptz_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [dptz_pkg::SRC_W-1:0]              i_cfg_data,
    // result channel
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output logic                                    o_crop_enable,
    output logic [dptz_pkg::OFS_W-1:0]              o_crop_x,
    output logic [dptz_pkg::OFS_W-1:0]              o_crop_y,
    output logic [dptz_pkg::SRC_W-1:0]              o_crop_width,
    output logic [dptz_pkg::SRC_W-1:0]              o_crop_height
);

    localparam int ZW = dptz_pkg::ZOOM_W;
    localparam int CW = dptz_pkg::CTR_W;
    localparam int UW = dptz_pkg::SUM_W;

    typedef enum logic [1:0] {S_IDLE, S_CALC, S_LOAD} t_state;

    // Saturate a signed sum or argument into the zoom range.
    function automatic logic [ZW-1:0] clamp_zoom(input logic signed [UW-1:0] v);
        if (v < $signed(UW'(dptz_pkg::ZOOM_ONE))) begin
            return dptz_pkg::ZOOM_ONE;
        end else if (v > $signed(UW'(dptz_pkg::ZOOM_MAX))) begin
            return dptz_pkg::ZOOM_MAX;
        end else begin
            return v[ZW-1:0];
        end
    endfunction

    // Saturate a signed sum or argument into 0..1.0.
    function automatic logic [CW-1:0] clamp_center(input logic signed [UW-1:0] v);
        if (v < $signed(UW'(0))) begin
            return '0;
        end else if (v > $signed(UW'(dptz_pkg::CENTER_ONE))) begin
            return dptz_pkg::CENTER_ONE;
        end else begin
            return v[CW-1:0];
        end
    endfunction

    t_state                      r_state;
    logic                        r_start;
    logic [ZW-1:0]               r_zoom;
    logic [CW-1:0]               r_cx;
    logic [CW-1:0]               r_cy;
    logic                        r_on;
    logic [dptz_pkg::SRC_W-1:0]  r_src_w;
    logic [dptz_pkg::SRC_W-1:0]  r_src_h;
    logic                        r_out_valid;
    logic                        r_crop_enable;
    logic [dptz_pkg::OFS_W-1:0]  r_crop_x;
    logic [dptz_pkg::OFS_W-1:0]  r_crop_y;
    logic [dptz_pkg::SRC_W-1:0]  r_crop_width;
    logic [dptz_pkg::SRC_W-1:0]  r_crop_height;

    logic [ZW-1:0]               n_zoom;
    logic [CW-1:0]               n_cx;
    logic [CW-1:0]               n_cy;
    logic                        n_on;
    logic                        n_emit;
    logic signed [UW-1:0]        zoom_sum;
    logic signed [UW-1:0]        cx_sum;
    logic signed [UW-1:0]        cy_sum;
    logic                        accept;
    logic                        out_free;
    logic                        done_x;
    logic                        done_y;
    dptz_pkg::t_axis_res         res_x;
    dptz_pkg::t_axis_res         res_y;

    assign accept   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    assign zoom_sum = $signed(UW'(r_zoom)) + UW'(i_zoom_arg);
    assign cx_sum   = $signed(UW'(r_cx)) + UW'(i_center_x_arg);
    assign cy_sum   = $signed(UW'(r_cy)) + UW'(i_center_y_arg);

    // Decode the command into the next view; ops that only move the view
    // report only while the crop is on.
    always_comb begin
        n_zoom = r_zoom;
        n_cx   = r_cx;
        n_cy   = r_cy;
        n_on   = r_on;
        n_emit = r_on;
        case (dptz_pkg::t_opcode'(i_opcode))
            dptz_pkg::OP_SET_ZOOM:   n_zoom = clamp_zoom(UW'(i_zoom_arg));
            dptz_pkg::OP_ZOOM_STEP:  n_zoom = clamp_zoom(zoom_sum);
            dptz_pkg::OP_SET_CENTER: begin
                n_cx = clamp_center(UW'(i_center_x_arg));
                n_cy = clamp_center(UW'(i_center_y_arg));
            end
            dptz_pkg::OP_PAN:        n_cx = clamp_center(cx_sum);
            dptz_pkg::OP_TILT:       n_cy = clamp_center(cy_sum);
            dptz_pkg::OP_RESET_VIEW: begin
                n_zoom = dptz_pkg::ZOOM_ONE;
                n_cx   = dptz_pkg::CENTER_HALF;
                n_cy   = dptz_pkg::CENTER_HALF;
            end
            dptz_pkg::OP_ENABLE: begin
                n_on   = i_enable_arg;
                n_emit = 1'b1;
            end
            default: n_emit = 1'b1;  // reapply
        endcase
    end

    // Source size registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= dptz_pkg::SRC_W_RESET;
            r_src_h <= dptz_pkg::SRC_H_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                dptz_pkg::CFG_SOURCE_WIDTH:  r_src_w <= i_cfg_data;
                dptz_pkg::CFG_SOURCE_HEIGHT: r_src_h <= i_cfg_data;
                default: ;  // drop writes to unused indexes
            endcase
        end
    end

    // Command sequencer, view state and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_start     <= 1'b0;
            r_zoom      <= dptz_pkg::ZOOM_ONE;
            r_cx        <= dptz_pkg::CENTER_HALF;
            r_cy        <= dptz_pkg::CENTER_HALF;
            r_on        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // pulse start for one cycle when an accepted command reports
            r_start <= (r_state == S_IDLE) && accept && n_emit;
            // load a new result, or drop the held one once it is taken
            if ((r_state == S_LOAD) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_zoom <= n_zoom;
                        r_cx   <= n_cx;
                        r_cy   <= n_cy;
                        r_on   <= n_on;
                        if (n_emit) begin
                            r_state <= S_CALC;
                        end
                    end
                end
                S_CALC: begin
                    if (done_x && done_y) begin
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    // hold the rectangle until the output register frees up
                    if (out_free) begin
                        r_crop_enable <= r_on;
                        r_crop_x      <= r_on ? res_x.offset : '0;
                        r_crop_y      <= r_on ? res_y.offset : '0;
                        r_crop_width  <= r_on ? res_x.size : '0;
                        r_crop_height <= r_on ? res_y.size : '0;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    dptz_axis #(
        .MIN_CROP  (MIN_CROP)
    ) u_axis_x (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_start),
        .i_src    (r_src_w),
        .i_zoom   (r_zoom),
        .i_center (r_cx),
        .o_done   (done_x),
        .o_res    (res_x)
    );

    dptz_axis #(
        .MIN_CROP  (MIN_CROP)
    ) u_axis_y (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_start),
        .i_src    (r_src_h),
        .i_zoom   (r_zoom),
        .i_center (r_cy),
        .o_done   (done_y),
        .o_res    (res_y)
    );

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign o_out_valid   = r_out_valid;
    assign o_crop_enable = r_crop_enable;
    assign o_crop_x      = r_crop_x;
    assign o_crop_y      = r_crop_y;
    assign o_crop_width  = r_crop_width;
    assign o_crop_height = r_crop_height;

endmodule

>>> rtl/core/dptz_checker.sv
// ----------------------------------------------------------------------------
// Digital pan-tilt-zoom crop: port checker
// Concurrent checks on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "digital_pan_tilt_zoom_crop_top_macros.svh"

module dptz_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_in_valid,
    input logic                                 o_in_ready,
    input logic [2:0]                           i_opcode,
    input logic                                 o_out_valid,
    input logic                                 i_out_ready,
    input logic                                 o_crop_enable,
    input logic [dptz_pkg::OFS_W-1:0]           o_crop_x,
    input logic [dptz_pkg::OFS_W-1:0]           o_crop_y,
    input logic [dptz_pkg::SRC_W-1:0]           o_crop_width,
    input logic [dptz_pkg::SRC_W-1:0]           o_crop_height
);

    // A stalled result holds.
    `DPTZ_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_crop_x) && $stable(o_crop_y) && $stable(o_crop_width) && $stable(o_crop_height) && $stable(o_crop_enable), "stalled result changed")

    // Crop off reports an empty rectangle.
    `DPTZ_ASSERT_IMPL(a_off_zero, o_out_valid && !o_crop_enable, o_crop_x == '0 && o_crop_y == '0 && o_crop_width == '0 && o_crop_height == '0, "crop off with nonzero rectangle")

    // Every coordinate of a live rectangle is even.
    `DPTZ_ASSERT_IMPL(a_even, o_out_valid && o_crop_enable, !o_crop_x[0] && !o_crop_y[0] && !o_crop_width[0] && !o_crop_height[0], "odd crop coordinate")

    // Reapply always computes, so the command port drops ready.
    `DPTZ_ASSERT_NEXT(a_reapply_busy, i_in_valid && o_in_ready && i_opcode == dptz_pkg::OP_REAPPLY, !o_in_ready, "reapply did not start a computation")

endmodule

bind digital_pan_tilt_zoom_crop_top dptz_checker u_dptz_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .i_opcode      (i_opcode),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_crop_enable (o_crop_enable),
    .o_crop_x      (o_crop_x),
    .o_crop_y      (o_crop_y),
    .o_crop_width  (o_crop_width),
    .o_crop_height (o_crop_height)
);

>>> bench/digital_pan_tilt_zoom_crop_top_tb.sv
// ----------------------------------------------------------------------------
// Digital pan-tilt-zoom crop: testbench
// Drives command items and source-size writes into the crop controller, keeps
// its own view state to predict every crop rectangle, and checks each result
// item in order against that prediction under random idling on both sides.
// ----------------------------------------------------------------------------
module digital_pan_tilt_zoom_crop_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ARG_W        = dptz_pkg::ARG_W;
    localparam int SRC_W        = dptz_pkg::SRC_W;
    localparam int OFS_W        = dptz_pkg::OFS_W;
    localparam int CFG_IDX_W    = dptz_pkg::CFG_IDX_W;

    localparam int CROP_FLOOR   = 64;
    localparam int DIM_BITS     = 14;
    localparam int SRC_CAP      = 1 << (DIM_BITS - 1);
    localparam int ZOOM_LO      = int'(dptz_pkg::ZOOM_ONE);
    localparam int ZOOM_HI      = int'(dptz_pkg::ZOOM_MAX);
    localparam int CTR_HI       = int'(dptz_pkg::CENTER_ONE);
    localparam int CTR_MID      = int'(dptz_pkg::CENTER_HALF);
    localparam int ARG_MAX      = (1 << (ARG_W - 1)) - 1;
    localparam int ARG_MIN      = -(1 << (ARG_W - 1));
    localparam int SRC_FULL     = (1 << SRC_W) - 1;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 125;
    localparam int PRESS_ITEMS  = 60;
    localparam int SINK_HOLD    = 400;
    localparam int SETTLE       = 30;

    typedef struct {
        dptz_pkg::t_opcode       op;
        logic signed [ARG_W-1:0] zoom_arg;
        logic signed [ARG_W-1:0] center_x_arg;
        logic signed [ARG_W-1:0] center_y_arg;
        logic                    enable_arg;
    } t_view_cmd;

    typedef struct {
        logic             crop_enable;
        logic [OFS_W-1:0] crop_x;
        logic [OFS_W-1:0] crop_y;
        logic [SRC_W-1:0] crop_width;
        logic [SRC_W-1:0] crop_height;
    } t_crop_rect;

    // Tracks the view state and holds the crop rectangles still owed by the block.
    class crop_scoreboard;
        int         src_w;
        int         src_h;
        int         zoom;
        int         ctr_x;
        int         ctr_y;
        bit         on;
        int         errors;
        t_crop_rect owed_rects[$];

        function new();
            src_w  = int'(dptz_pkg::SRC_W_RESET);
            src_h  = int'(dptz_pkg::SRC_H_RESET);
            zoom   = ZOOM_LO;
            ctr_x  = CTR_MID;
            ctr_y  = CTR_MID;
            on     = 1'b0;
            errors = 0;
        endfunction

        function int clamp(int v, int lo, int hi);
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        endfunction

        function void write_source(logic [CFG_IDX_W-1:0] idx,
                                   logic [SRC_W-1:0] data);
            if (idx == dptz_pkg::CFG_SOURCE_WIDTH) begin
                src_w = int'(data);
            end else if (idx == dptz_pkg::CFG_SOURCE_HEIGHT) begin
                src_h = int'(data);
            end
        endfunction

        function void crop_axis(int src, int ctr, output int ofs, output int size);
            int s;
            int w;
            int x;
            s = (src > SRC_CAP) ? SRC_CAP : src;
            w = (s * 4096) / zoom;
            if (w < CROP_FLOOR) w = CROP_FLOOR;
            if (w > s) w = s;
            w = w & ~1;
            x = ((ctr * s) >> 16) - w / 2;
            if (x < 0) x = 0;
            if (x > s - w) x = s - w;
            ofs  = x & ~1;
            size = w;
        endfunction

        function t_crop_rect view_rect();
            t_crop_rect r;
            int ofs;
            int size;
            r.crop_enable = on;
            r.crop_x      = '0;
            r.crop_y      = '0;
            r.crop_width  = '0;
            r.crop_height = '0;
            if (on) begin
                crop_axis(src_w, ctr_x, ofs, size);
                r.crop_x     = OFS_W'(ofs);
                r.crop_width = SRC_W'(size);
                crop_axis(src_h, ctr_y, ofs, size);
                r.crop_y      = OFS_W'(ofs);
                r.crop_height = SRC_W'(size);
            end
            return r;
        endfunction

        // Apply one accepted command to the view and owe a rectangle if it emits.
        function void note_cmd(t_view_cmd c);
            int za;
            int xa;
            int ya;
            bit forced;
            za     = c.zoom_arg;
            xa     = c.center_x_arg;
            ya     = c.center_y_arg;
            forced = 1'b0;
            case (c.op)
                dptz_pkg::OP_SET_ZOOM:   zoom = clamp(za, ZOOM_LO, ZOOM_HI);
                dptz_pkg::OP_ZOOM_STEP:  zoom = clamp(zoom + za, ZOOM_LO, ZOOM_HI);
                dptz_pkg::OP_SET_CENTER: begin
                    ctr_x = clamp(xa, 0, CTR_HI);
                    ctr_y = clamp(ya, 0, CTR_HI);
                end
                dptz_pkg::OP_PAN:        ctr_x = clamp(ctr_x + xa, 0, CTR_HI);
                dptz_pkg::OP_TILT:       ctr_y = clamp(ctr_y + ya, 0, CTR_HI);
                dptz_pkg::OP_RESET_VIEW: begin
                    zoom  = ZOOM_LO;
                    ctr_x = CTR_MID;
                    ctr_y = CTR_MID;
                end
                dptz_pkg::OP_ENABLE: begin
                    on     = c.enable_arg;
                    forced = 1'b1;
                end
                default:       forced = 1'b1;
            endcase
            if (forced || on) owed_rects.push_back(view_rect());
        endfunction

        function void cmp_field(string name, logic [SRC_W-1:0] exp_v,
                                logic [SRC_W-1:0] got_v);
            if (got_v !== exp_v) begin
                $error("%s: expected %0d, got %0d", name, exp_v, got_v);
                errors++;
            end
        endfunction

        function void check_rect(t_crop_rect got);
            t_crop_rect exp_r;
            if (owed_rects.size() == 0) begin
                $error("result item with nothing outstanding: en=%0d x=%0d y=%0d w=%0d h=%0d",
                       got.crop_enable, got.crop_x, got.crop_y, got.crop_width,
                       got.crop_height);
                errors++;
                return;
            end
            exp_r = owed_rects.pop_front();
            cmp_field("crop_enable", exp_r.crop_enable, got.crop_enable);
            cmp_field("crop_x", exp_r.crop_x, got.crop_x);
            cmp_field("crop_y", exp_r.crop_y, got.crop_y);
            cmp_field("crop_width", exp_r.crop_width, got.crop_width);
            cmp_field("crop_height", exp_r.crop_height, got.crop_height);
        endfunction

        function int pending();
            return owed_rects.size();
        endfunction
    endclass

    // Block ports; every input starts at a known value.
    logic                    clk          = 1'b0;
    logic                    rst_n        = 1'b0;
    logic                    in_valid     = 1'b0;
    dptz_pkg::t_opcode       opcode       = dptz_pkg::OP_REAPPLY;
    logic signed [ARG_W-1:0] zoom_arg     = '0;
    logic signed [ARG_W-1:0] center_x_arg = '0;
    logic signed [ARG_W-1:0] center_y_arg = '0;
    logic                    enable_arg   = 1'b0;
    logic                    cfg_valid    = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index    = dptz_pkg::CFG_SOURCE_WIDTH;
    logic [SRC_W-1:0]        cfg_data     = '0;
    logic                    out_ready    = 1'b0;
    logic                    in_ready;
    logic                    cfg_ready;
    logic                    out_valid;
    logic                    crop_enable;
    logic [OFS_W-1:0]        crop_x;
    logic [OFS_W-1:0]        crop_y;
    logic [SRC_W-1:0]        crop_width;
    logic [SRC_W-1:0]        crop_height;

    // Shared flags: steady turns idling off on both sides, sink_hold asks for
    // one long receiver stall.
    bit steady    = 1'b0;
    bit sink_hold = 1'b0;

    crop_scoreboard sb = new();

    int src_w_list [9] = '{0, 1, 2, 8192, SRC_FULL, 64, 63, 1920, 8191};
    int src_h_list [9] = '{1, 0, 8192, 2, SRC_FULL, 65, 100, 1080, 4097};

    digital_pan_tilt_zoom_crop_top u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_opcode       (opcode),
        .i_zoom_arg     (zoom_arg),
        .i_center_x_arg (center_x_arg),
        .i_center_y_arg (center_y_arg),
        .i_enable_arg   (enable_arg),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_crop_enable  (crop_enable),
        .o_crop_x       (crop_x),
        .o_crop_y       (crop_y),
        .o_crop_width   (crop_width),
        .o_crop_height  (crop_height)
    );

    always #6 clk = ~clk;

    // Gap length: mostly none, often short, now and then long.
    function automatic int gap_len();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [ARG_W-1:0] near(int lo, int hi);
        return ARG_W'(int'($urandom_range(0, hi - lo)) + lo);
    endfunction

    function automatic t_view_cmd mk(dptz_pkg::t_opcode op, int z, int x, int y, bit en);
        t_view_cmd c;
        c.op           = op;
        c.zoom_arg     = ARG_W'(z);
        c.center_x_arg = ARG_W'(x);
        c.center_y_arg = ARG_W'(y);
        c.enable_arg   = en;
        return c;
    endfunction

    // Random command: all fields random, then the used ones mostly pulled
    // into the interesting range so that clamps and crops both get exercised.
    function automatic t_view_cmd rand_cmd();
        t_view_cmd c;
        int r;
        bit tame;
        c.zoom_arg     = ARG_W'($urandom);
        c.center_x_arg = ARG_W'($urandom);
        c.center_y_arg = ARG_W'($urandom);
        c.enable_arg   = ($urandom_range(0, 4) != 0);
        tame           = ($urandom_range(0, 4) != 0);
        r              = $urandom_range(0, 99);
        if (r < 14) begin
            c.op = dptz_pkg::OP_SET_ZOOM;
            if (tame) c.zoom_arg = near(2048, 36864);
        end else if (r < 32) begin
            c.op = dptz_pkg::OP_ZOOM_STEP;
            if (tame) c.zoom_arg = near(-6000, 6000);
        end else if (r < 46) begin
            c.op = dptz_pkg::OP_SET_CENTER;
            if (tame) begin
                c.center_x_arg = near(-4000, 70000);
                c.center_y_arg = near(-4000, 70000);
            end
        end else if (r < 62) begin
            c.op = dptz_pkg::OP_PAN;
            if (tame) c.center_x_arg = near(-20000, 20000);
        end else if (r < 78) begin
            c.op = dptz_pkg::OP_TILT;
            if (tame) c.center_y_arg = near(-20000, 20000);
        end else if (r < 83) begin
            c.op = dptz_pkg::OP_RESET_VIEW;
        end else if (r < 93) begin
            c.op = dptz_pkg::OP_ENABLE;
        end else begin
            c.op = dptz_pkg::OP_REAPPLY;
        end
        return c;
    endfunction

    function automatic logic [SRC_W-1:0] rand_source();
        case ($urandom_range(0, 3))
            0:       return SRC_W'($urandom_range(2, 200));
            1, 2:    return SRC_W'($urandom_range(200, 4000));
            default: return SRC_W'($urandom_range(4000, SRC_FULL));
        endcase
    endfunction

    // Offer one command and hold it until taken; valid stays high afterwards.
    task automatic send_cmd(t_view_cmd c);
        in_valid     <= 1'b1;
        opcode       <= c.op;
        zoom_arg     <= c.zoom_arg;
        center_x_arg <= c.center_x_arg;
        center_y_arg <= c.center_y_arg;
        enable_arg   <= c.enable_arg;
        do @(posedge clk); while (!in_ready);
        sb.note_cmd(c);
    endtask

    task automatic issue(t_view_cmd c);
        int g;
        send_cmd(c);
        g = gap_len();
        if (g > 0) begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic pause_in();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Wait for every owed rectangle, then let a command with no result finish.
    task automatic drain();
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SRC_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.write_source(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Result side: pick a ready level and hold it for a while; one long
    // stall when asked.
    initial begin : result_sink
        int k;
        @(posedge clk);
        forever begin
            if (sink_hold) begin
                out_ready <= 1'b0;
                k         = SINK_HOLD;
                sink_hold = 1'b0;
            end else if (steady) begin
                out_ready <= 1'b1;
                k         = 1;
            end else if ($urandom_range(0, 3) == 0) begin
                out_ready <= 1'b0;
                k         = gap_len() + 1;
            end else begin
                out_ready <= 1'b1;
                k         = $urandom_range(1, 6);
            end
            repeat (k) @(posedge clk);
        end
    end

    always @(posedge clk) begin : result_monitor
        t_crop_rect got;
        if (rst_n && out_valid && out_ready) begin
            got.crop_enable = crop_enable;
            got.crop_x      = crop_x;
            got.crop_y      = crop_y;
            got.crop_width  = crop_width;
            got.crop_height = crop_height;
            sb.check_rect(got);
        end
    end

    initial begin : stimulus
        logic [SRC_W-1:0] w;
        logic [SRC_W-1:0] h;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: argument extremes, every opcode, crop off and on.
        issue(mk(dptz_pkg::OP_REAPPLY, 0, 0, 0, 1'b0));
        issue(mk(dptz_pkg::OP_SET_ZOOM, ARG_MAX, 0, 0, 1'b0));
        issue(mk(dptz_pkg::OP_PAN, 0, 7000, 0, 1'b0));
        issue(mk(dptz_pkg::OP_ENABLE, 0, 0, 0, 1'b1));
        issue(mk(dptz_pkg::OP_SET_ZOOM, ARG_MIN, 0, 0, 1'b0));
        issue(mk(dptz_pkg::OP_SET_ZOOM, 8192, 0, 0, 1'b0));
        issue(mk(dptz_pkg::OP_ZOOM_STEP, ARG_MAX, 0, 0, 1'b0));
        issue(mk(dptz_pkg::OP_ZOOM_STEP, ARG_MIN, 0, 0, 1'b0));
        issue(mk(dptz_pkg::OP_ZOOM_STEP, 12288, 0, 0, 1'b0));
        issue(mk(dptz_pkg::OP_SET_CENTER, 0, ARG_MAX, ARG_MIN, 1'b0));
        issue(mk(dptz_pkg::OP_SET_CENTER, 0, ARG_MIN, ARG_MAX, 1'b0));
        issue(mk(dptz_pkg::OP_PAN, 0, ARG_MAX, 0, 1'b0));
        issue(mk(dptz_pkg::OP_PAN, 0, ARG_MIN, 0, 1'b0));
        issue(mk(dptz_pkg::OP_TILT, 0, 0, ARG_MIN, 1'b0));
        issue(mk(dptz_pkg::OP_TILT, 0, 0, ARG_MAX, 1'b0));
        issue(mk(dptz_pkg::OP_SET_CENTER, 0, 1000, 64536, 1'b0));
        issue(mk(dptz_pkg::OP_ZOOM_STEP, -1, 0, 0, 1'b0));
        issue(mk(dptz_pkg::OP_RESET_VIEW, ARG_MAX, ARG_MAX, ARG_MAX, 1'b1));
        issue(mk(dptz_pkg::OP_SET_ZOOM, 32767, 0, 0, 1'b0));
        issue(mk(dptz_pkg::OP_ENABLE, ARG_MIN, ARG_MIN, ARG_MIN, 1'b0));
        issue(mk(dptz_pkg::OP_TILT, 0, 0, 5000, 1'b0));
        issue(mk(dptz_pkg::OP_REAPPLY, 0, 0, 0, 1'b0));
        issue(mk(dptz_pkg::OP_ENABLE, -1, -1, -1, 1'b1));
        issue(mk(dptz_pkg::OP_REAPPLY, 0, 0, 0, 1'b0));
        pause_in();
        drain();

        // Back-pressure: stall the receiver long while items keep coming.
        steady    = 1'b1;
        sink_hold = 1'b1;
        issue(mk(dptz_pkg::OP_ENABLE, 0, 0, 0, 1'b1));
        repeat (PRESS_ITEMS) issue(rand_cmd());
        pause_in();
        steady = 1'b0;
        drain();

        // Random phases, each under its own source size.
        for (int p = 0; p < PHASES; p++) begin
            if (p < 9) begin
                w = SRC_W'(src_w_list[p]);
                h = SRC_W'(src_h_list[p]);
            end else begin
                w = rand_source();
                h = rand_source();
            end
            write_reg(dptz_pkg::CFG_SOURCE_WIDTH, w);
            write_reg(dptz_pkg::CFG_SOURCE_HEIGHT, h);
            write_reg(CFG_SPARE_A, SRC_W'($urandom));
            write_reg(CFG_SPARE_B, SRC_W'($urandom));
            steady = (p % 4 == 2);
            issue(mk(dptz_pkg::OP_ENABLE, 0, 0, 0, 1'b1));
            repeat (PHASE_ITEMS) issue(rand_cmd());
            pause_in();
            steady = 1'b0;
            drain();
        end

        if (sb.pending() != 0) begin
            $error("%0d crop rectangles never arrived", sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("** digital_pan_tilt_zoom_crop_top: PASSED **");
        end else begin
            $display("** digital_pan_tilt_zoom_crop_top: FAILED **");
        end
        $finish;
    end

    initial begin : watchdog
        #10ms;
        $display("** digital_pan_tilt_zoom_crop_top: FAILED **");
        $finish;
    end

endmodule
